// File: rtl/pdz_pkg.sv
// Shared types, codes and constants for the pulse dialer and zip sender.
// No dependencies; every other file in rtl/ imports this package.
package pdz_pkg;

  localparam int unsigned CFG_W   = 12;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned VALUE_W = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned REP_W   = 4;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DIAL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEND = 2'd2;
  localparam logic [KIND_W-1:0] KIND_HOOK = 2'd3;

  // Register indexes.
  localparam logic [ADDR_W-1:0] REG_BREAK     = 3'd0;
  localparam logic [ADDR_W-1:0] REG_MAKE      = 3'd1;
  localparam logic [ADDR_W-1:0] REG_INTERDIG  = 3'd2;
  localparam logic [ADDR_W-1:0] REG_ZIP       = 3'd3;
  localparam logic [ADDR_W-1:0] REG_ZIP_GAP   = 3'd4;
  localparam logic [ADDR_W-1:0] REG_GROUP_GAP = 3'd5;

  // Register reset values.
  localparam logic [CFG_W-1:0] BREAK_RST     = 12'd63;
  localparam logic [CFG_W-1:0] MAKE_RST      = 12'd37;
  localparam logic [CFG_W-1:0] INTERDIG_RST  = 12'd500;
  localparam logic [CFG_W-1:0] ZIP_RST       = 12'd200;
  localparam logic [CFG_W-1:0] ZIP_GAP_RST   = 12'd200;
  localparam logic [CFG_W-1:0] GROUP_GAP_RST = 12'd500;

  // Digit groups of a quantity.
  localparam logic [1:0] GRP_HUNDREDS = 2'd0;
  localparam logic [1:0] GRP_TENS     = 2'd1;
  localparam logic [1:0] GRP_UNITS    = 2'd2;

  // A zero digit is sent as ten pulses or zips.
  localparam logic [REP_W-1:0] ZERO_REPEATS = 4'd10;
  localparam logic [VALUE_W-1:0] MAX_DIGIT  = 8'd9;

  typedef enum logic [2:0] {
    ACT_IDLE = 3'b001,
    ACT_DIAL = 3'b010,
    ACT_SEND = 3'b100
  } act_t;

  // First phase is the break when dialing and the tone when sending.
  typedef enum logic [2:0] {
    PH_FIRST  = 3'b001,
    PH_SECOND = 3'b010,
    PH_GAP    = 3'b100
  } phase_t;

  // Effective phase lengths in ticks, already cleaned up.
  typedef struct packed {
    logic [CFG_W-1:0] brk;
    logic [CFG_W-1:0] make;
    logic [CFG_W-1:0] interdig;
    logic [CFG_W-1:0] zip;
    logic [CFG_W-1:0] zip_gap;
    logic [CFG_W-1:0] group_gap;
  } cfg_len_t;

  typedef struct packed {
    logic line_closed;
    logic speaker;
    logic busy_res;
    logic rejected;
    logic finished;
  } result_t;

endpackage

// File: rtl/pdz_cfg_regs.sv
// Configuration register file for the pulse dialer and zip sender.
// Depends on pdz_pkg; turns stored values into effective phase lengths.
module pdz_cfg_regs import pdz_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [CFG_W-1:0]  wr_data,
  output cfg_len_t          len
);

  logic [CFG_W-1:0] brk_r, make_r, interdig_r, zip_r, zip_gap_r, group_gap_r;
  logic [CFG_W-1:0] zip_even;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brk_r       <= BREAK_RST;
      make_r      <= MAKE_RST;
      interdig_r  <= INTERDIG_RST;
      zip_r       <= ZIP_RST;
      zip_gap_r   <= ZIP_GAP_RST;
      group_gap_r <= GROUP_GAP_RST;
    end else if (wr_en) begin
      case (wr_addr)
        REG_BREAK:     brk_r       <= wr_data;
        REG_MAKE:      make_r      <= wr_data;
        REG_INTERDIG:  interdig_r  <= wr_data;
        REG_ZIP:       zip_r       <= wr_data;
        REG_ZIP_GAP:   zip_gap_r   <= wr_data;
        REG_GROUP_GAP: group_gap_r <= wr_data;
        default: ;
      endcase
    end
  end

  // A zero length acts as one tick; the tone length is forced even and at least two.
  assign zip_even = {zip_r[CFG_W-1:1], 1'b0};

  always_comb begin
    len.brk       = (brk_r       == '0) ? CFG_W'(1) : brk_r;
    len.make      = (make_r      == '0) ? CFG_W'(1) : make_r;
    len.interdig  = (interdig_r  == '0) ? CFG_W'(1) : interdig_r;
    len.zip       = (zip_even    == '0) ? CFG_W'(2) : zip_even;
    len.zip_gap   = (zip_gap_r   == '0) ? CFG_W'(1) : zip_gap_r;
    len.group_gap = (group_gap_r == '0) ? CFG_W'(1) : group_gap_r;
  end

endmodule

// File: rtl/pdz_seq.sv
// Sequencer state and its next-state logic for the dialer and zip sender.
// Depends on pdz_pkg; the state moves only when the top level steps it.
module pdz_seq import pdz_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [KIND_W-1:0]  kind,
  input  logic [VALUE_W-1:0] value,
  input  cfg_len_t           len,
  output result_t            res
);

  logic             off_hook_r, off_hook_nxt;
  act_t             act_r, act_nxt;
  phase_t           ph_r, ph_nxt;
  logic [CFG_W-1:0] tick_r, tick_nxt;
  logic [REP_W-1:0] rep_r, rep_nxt;
  logic [1:0]       hun_r, hun_nxt;
  logic [3:0]       ten_r, ten_nxt;
  logic [3:0]       uni_r, uni_nxt;
  logic [1:0]       grp_r, grp_nxt;
  logic             tone_r, tone_nxt;

  logic [CFG_W-1:0] cur_len;
  logic             phase_done;
  logic             busy;
  logic             rej, fin;
  logic [1:0]       q_hun;
  logic [6:0]       q_rem;
  logic [14:0]      q_prod;
  logic [3:0]       q_ten;
  logic [3:0]       q_uni;
  logic [1:0]       grp_inc;
  logic [3:0]       next_digit;
  logic [REP_W-1:0] rep_dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_hook_r <= 1'b0;
      act_r      <= ACT_IDLE;
      ph_r       <= PH_FIRST;
      tick_r     <= '0;
      rep_r      <= '0;
      hun_r      <= '0;
      ten_r      <= '0;
      uni_r      <= '0;
      grp_r      <= GRP_HUNDREDS;
      tone_r     <= 1'b0;
    end else if (step) begin
      off_hook_r <= off_hook_nxt;
      act_r      <= act_nxt;
      ph_r       <= ph_nxt;
      tick_r     <= tick_nxt;
      rep_r      <= rep_nxt;
      hun_r      <= hun_nxt;
      ten_r      <= ten_nxt;
      uni_r      <= uni_nxt;
      grp_r      <= grp_nxt;
      tone_r     <= tone_nxt;
    end
  end

  assign busy = (act_r != ACT_IDLE);

  always_comb begin
    case (ph_r)
      PH_FIRST:  cur_len = (act_r == ACT_DIAL) ? len.brk  : len.zip;
      PH_SECOND: cur_len = (act_r == ACT_DIAL) ? len.make : len.zip_gap;
      default:   cur_len = (act_r == ACT_DIAL) ? len.interdig : len.group_gap;
    endcase
  end

  assign phase_done = ({1'b0, tick_r} + 13'd1) >= {1'b0, cur_len};

  // Split a quantity into decimal digits; x*205>>11 is x/10 for x below 100.
  assign q_hun  = (value >= 8'd200) ? 2'd2 : ((value >= 8'd100) ? 2'd1 : 2'd0);
  assign q_rem  = 7'(value - 8'(q_hun) * 8'd100);
  assign q_prod = 15'(q_rem) * 15'd205;
  assign q_ten  = q_prod[14:11];
  assign q_uni  = 4'(q_rem - 7'(q_ten) * 7'd10);

  assign grp_inc    = grp_r + 2'd1;
  assign next_digit = (grp_inc == GRP_TENS) ? ten_r : uni_r;
  assign rep_dec    = rep_r - REP_W'(1);

  always_comb begin
    off_hook_nxt = off_hook_r;
    act_nxt      = act_r;
    ph_nxt       = ph_r;
    tick_nxt     = tick_r;
    rep_nxt      = rep_r;
    hun_nxt      = hun_r;
    ten_nxt      = ten_r;
    uni_nxt      = uni_r;
    grp_nxt      = grp_r;
    tone_nxt     = tone_r;
    rej          = 1'b0;
    fin          = 1'b0;

    if (kind == KIND_TICK) begin
      if (busy) begin
        if (phase_done) begin
          tick_nxt = '0;
          case (ph_r)
            PH_FIRST: begin
              ph_nxt   = PH_SECOND;
              tone_nxt = (act_r == ACT_SEND) ? 1'b0 : tone_r;
            end
            PH_SECOND: begin
              rep_nxt = rep_dec;
              if (rep_dec != '0) begin
                ph_nxt   = PH_FIRST;
                tone_nxt = (act_r == ACT_SEND) ? 1'b1 : tone_r;
              end else if (act_r == ACT_SEND && grp_r < GRP_UNITS) begin
                ph_nxt = PH_GAP;
              end else if (act_r == ACT_SEND) begin
                act_nxt = ACT_IDLE;
                ph_nxt  = PH_FIRST;
                fin     = 1'b1;
              end else begin
                ph_nxt = PH_GAP;
              end
            end
            default: begin
              if (act_r == ACT_DIAL) begin
                act_nxt = ACT_IDLE;
                ph_nxt  = PH_FIRST;
                fin     = 1'b1;
              end else begin
                grp_nxt  = grp_inc;
                rep_nxt  = (next_digit == '0) ? ZERO_REPEATS : next_digit;
                ph_nxt   = PH_FIRST;
                tone_nxt = 1'b1;
              end
            end
          endcase
        end else begin
          tick_nxt = tick_r + CFG_W'(1);
          if (act_r == ACT_SEND && ph_r == PH_FIRST) begin
            tone_nxt = ~tone_r;
          end
        end
      end
    end else if (busy) begin
      rej = 1'b1;
    end else if (kind == KIND_DIAL) begin
      if (value > MAX_DIGIT) begin
        rej = 1'b1;
      end else begin
        act_nxt  = ACT_DIAL;
        rep_nxt  = (value == '0) ? ZERO_REPEATS : value[REP_W-1:0];
        ph_nxt   = PH_FIRST;
        tick_nxt = '0;
      end
    end else if (kind == KIND_SEND) begin
      act_nxt  = ACT_SEND;
      hun_nxt  = q_hun;
      ten_nxt  = q_ten;
      uni_nxt  = q_uni;
      ph_nxt   = PH_FIRST;
      tick_nxt = '0;
      tone_nxt = 1'b1;
      if (value > 8'd99) begin
        grp_nxt = GRP_HUNDREDS;
        rep_nxt = (q_hun == '0) ? ZERO_REPEATS : REP_W'(q_hun);
      end else begin
        grp_nxt = GRP_TENS;
        rep_nxt = (q_ten == '0) ? ZERO_REPEATS : q_ten;
      end
    end else begin
      off_hook_nxt = value[0];
    end
  end

  // The result shows the state after the item has been applied.
  always_comb begin
    res.line_closed = off_hook_nxt && !(act_nxt == ACT_DIAL && ph_nxt == PH_FIRST);
    res.speaker     = (act_nxt == ACT_SEND) && (ph_nxt == PH_FIRST) && tone_nxt;
    res.busy_res    = (act_nxt != ACT_IDLE);
    res.rejected    = rej;
    res.finished    = fin;
  end

endmodule

// File: rtl/pulse_dialer_and_zip_sender.sv
// Top level of the tick-driven rotary pulse dialer and zip-tone sender.
// Depends on pdz_pkg, pdz_cfg_regs and pdz_seq.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+----------------------------------
//  in_     | in        | in_tvalid/in_tready  | tuser: kind, tdata: value
//  out_    | out       | out_tvalid/out_tready| tdata: five result flags
//  cfg_    | in        | cfg_valid/cfg_ready  | cfg_addr: register, cfg_data
//
// Every accepted item yields exactly one result item, which the output
// register captures as the item moves on. The block takes one item per
// cycle; an item moves on when the output register is empty or being drained.
// Reset (rst_n low at a clock edge) puts the line on hook, the sequencer
// idle and the registers at their defaults. A stalled output holds its
// result and the input register, then in_tready, back-pressures upstream.
module pulse_dialer_and_zip_sender import pdz_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [VALUE_W-1:0] in_tdata,   // [7:0] value
  input  logic [KIND_W-1:0]  in_tuser,   // [1:0] kind
  output logic               out_tvalid,
  input  logic               out_tready,
  // [0] line_closed, [1] speaker, [2] busy_res, [3] rejected, [4] finished,
  // [7:5] zero
  output logic [7:0]         out_tdata,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_W-1:0]   cfg_data
);

  logic               in_vld_r;
  logic [KIND_W-1:0]  kind_r;
  logic [VALUE_W-1:0] value_r;
  logic               out_vld_r;
  result_t            res_r;
  result_t            res;
  cfg_len_t           len;
  logic               move;

  // The held item is processed when the result register can take its result.
  assign move      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || move;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      kind_r  <= in_tuser;
      value_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (move) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      res_r <= res;
    end
  end

  pdz_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_addr (cfg_addr),
    .wr_data (cfg_data),
    .len     (len)
  );

  pdz_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (move),
    .kind  (kind_r),
    .value (value_r),
    .len   (len),
    .res   (res)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, res_r.finished, res_r.rejected, res_r.busy_res,
                       res_r.speaker, res_r.line_closed};

endmodule
